FILE: hdl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants of the pump and bypass sequencer.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int MODE_W  = 3;
    localparam int KIND_W  = 4;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 3;
    // Widest limit in milliseconds is 65535 * 1000, which needs 26 bits.
    localparam int LIMIT_W = 26;
    localparam int OUT_W   = 8;

    localparam logic [LIMIT_W-1:0] MS_PER_SECOND = LIMIT_W'(1000);

    // Modes, as reported in the result.
    localparam logic [MODE_W-1:0] MODE_IDLE         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRIMING      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLOWOFF      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BYPASS_OPEN  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BYPASS_CLOSE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_MIX          = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DISABLED     = 3'd7;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK           = 4'd0;
    localparam logic [KIND_W-1:0] KIND_START          = 4'd1;
    localparam logic [KIND_W-1:0] KIND_STOP           = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DISABLE        = 4'd3;
    localparam logic [KIND_W-1:0] KIND_BLOWOFF        = 4'd4;
    localparam logic [KIND_W-1:0] KIND_MIX            = 4'd5;
    localparam logic [KIND_W-1:0] KIND_BYPASS_OPEN    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_BYPASS_BLOWOFF = 4'd7;
    localparam logic [KIND_W-1:0] KIND_BYPASS_CLOSE   = 4'd8;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_PRIMING_SECONDS      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PUMP_TIMEOUT_SECONDS = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BLOWOFF_SECONDS      = 3'd2;
    localparam logic [INDEX_W-1:0] REG_BYPASS_MAX_SECONDS   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BYPASS_CLOSE_MS      = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ENABLE_AT_RESET      = 3'd5;

    // Limits after reset, already scaled to milliseconds.
    localparam logic [LIMIT_W-1:0] PRIMING_MS_RESET      = LIMIT_W'(10000);
    localparam logic [LIMIT_W-1:0] PUMP_TIMEOUT_MS_RESET = LIMIT_W'(120000);
    localparam logic [LIMIT_W-1:0] BLOWOFF_MS_RESET      = LIMIT_W'(3000);
    localparam logic [LIMIT_W-1:0] BYPASS_MAX_MS_RESET   = LIMIT_W'(600000);
    localparam logic [LIMIT_W-1:0] BYPASS_CLOSE_MS_RESET = LIMIT_W'(600);
    localparam logic               ENABLE_AT_RESET       = 1'b1;

    // Per-mode time limits in milliseconds.
    typedef struct packed {
        logic [LIMIT_W-1:0] priming_ms;
        logic [LIMIT_W-1:0] pump_timeout_ms;
        logic [LIMIT_W-1:0] blowoff_ms;
        logic [LIMIT_W-1:0] bypass_max_ms;
        logic [LIMIT_W-1:0] bypass_close_ms;
    } pbs_limits_t;

    // Drives and flags that go with the mode.
    typedef struct packed {
        logic pump;
        logic bypass;
        logic enabled;
        logic timeout_event;
    } pbs_flags_t;

endpackage

FILE: hdl/pbs_cfg.sv
// ----------------------------------------------------------------------------
// pbs_cfg
// Configuration registers, held as limits already scaled to milliseconds.
// ----------------------------------------------------------------------------
module pbs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pbs_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [pbs_pkg::CFG_W-1:0]    cfg_wdata,
    output pbs_pkg::pbs_limits_t         limits
);

    pbs_pkg::pbs_limits_t       limits_reg;
    logic [pbs_pkg::LIMIT_W-1:0] scaled_ms;

    // Seconds are scaled on the way in, so the sequencer only compares.
    assign scaled_ms = pbs_pkg::LIMIT_W'(cfg_wdata) * pbs_pkg::MS_PER_SECOND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.priming_ms      <= pbs_pkg::PRIMING_MS_RESET;
            limits_reg.pump_timeout_ms <= pbs_pkg::PUMP_TIMEOUT_MS_RESET;
            limits_reg.blowoff_ms      <= pbs_pkg::BLOWOFF_MS_RESET;
            limits_reg.bypass_max_ms   <= pbs_pkg::BYPASS_MAX_MS_RESET;
            limits_reg.bypass_close_ms <= pbs_pkg::BYPASS_CLOSE_MS_RESET;
        end
        else if (cfg_we)
        begin
            // The start-up enable only matters at reset, where it is fixed,
            // so a write to it has nothing to store.
            unique case (cfg_index)
                pbs_pkg::REG_PRIMING_SECONDS:      limits_reg.priming_ms      <= scaled_ms;
                pbs_pkg::REG_PUMP_TIMEOUT_SECONDS: limits_reg.pump_timeout_ms <= scaled_ms;
                pbs_pkg::REG_BLOWOFF_SECONDS:      limits_reg.blowoff_ms      <= scaled_ms;
                pbs_pkg::REG_BYPASS_MAX_SECONDS:   limits_reg.bypass_max_ms   <= scaled_ms;
                pbs_pkg::REG_BYPASS_CLOSE_MS:
                    limits_reg.bypass_close_ms <= pbs_pkg::LIMIT_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign limits = limits_reg;

endmodule

FILE: hdl/pbs_step.sv
// ----------------------------------------------------------------------------
// pbs_step
// Next-state logic: applies one tick or command to the sequencer state.
// ----------------------------------------------------------------------------
module pbs_step #(
    parameter int TIMER_BITS = 27
) (
    input  logic [pbs_pkg::KIND_W-1:0] kind,
    input  logic                       reset_enable,
    input  pbs_pkg::pbs_limits_t       limits,
    input  logic [pbs_pkg::MODE_W-1:0] mode,
    input  logic [TIMER_BITS-1:0]      elapsed,
    input  pbs_pkg::pbs_flags_t        flags,
    output logic [pbs_pkg::MODE_W-1:0] mode_next,
    output logic [TIMER_BITS-1:0]      elapsed_next,
    output pbs_pkg::pbs_flags_t        flags_next
);

    localparam int CMP_W = (TIMER_BITS > pbs_pkg::LIMIT_W) ? TIMER_BITS : pbs_pkg::LIMIT_W;

    logic [TIMER_BITS-1:0]       elapsed_cur;
    logic [pbs_pkg::MODE_W-1:0]  req_mode;
    logic                        do_visit;
    logic                        en_cmd;
    logic                        en_visit;
    logic [pbs_pkg::LIMIT_W-1:0] limit_ms;
    logic                        expired;
    logic                        enter;
    logic [pbs_pkg::MODE_W-1:0]  target;
    logic                        event_fire;

    // Decode the command into a requested mode.
    always_comb
    begin
        elapsed_cur = elapsed;
        req_mode    = mode;
        do_visit    = 1'b0;
        en_cmd      = flags.enabled;
        unique case (kind) inside
            pbs_pkg::KIND_TICK:
            begin
                if (elapsed != {TIMER_BITS{1'b1}})
                begin
                    elapsed_cur = elapsed + 1'b1;
                end
                do_visit = 1'b1;
            end
            pbs_pkg::KIND_START:
            begin
                en_cmd   = flags.enabled | reset_enable;
                req_mode = pbs_pkg::MODE_PRIMING;
                do_visit = en_cmd;
            end
            pbs_pkg::KIND_STOP:
            begin
                en_cmd = flags.enabled | reset_enable;
                if (mode == pbs_pkg::MODE_RUNNING)
                begin
                    req_mode = pbs_pkg::MODE_BLOWOFF;
                    do_visit = 1'b1;
                end
                else if ((mode != pbs_pkg::MODE_IDLE && mode != pbs_pkg::MODE_DISABLED)
                         || (mode == pbs_pkg::MODE_DISABLED && reset_enable))
                begin
                    req_mode = pbs_pkg::MODE_BYPASS_CLOSE;
                    do_visit = 1'b1;
                end
            end
            pbs_pkg::KIND_DISABLE:
            begin
                en_cmd   = 1'b0;
                req_mode = (mode == pbs_pkg::MODE_RUNNING) ? pbs_pkg::MODE_BLOWOFF
                                                           : pbs_pkg::MODE_BYPASS_CLOSE;
                do_visit = 1'b1;
            end
            pbs_pkg::KIND_BLOWOFF, pbs_pkg::KIND_BYPASS_BLOWOFF:
            begin
                req_mode = pbs_pkg::MODE_BLOWOFF;
                do_visit = 1'b1;
            end
            pbs_pkg::KIND_MIX:
            begin
                req_mode = pbs_pkg::MODE_MIX;
                do_visit = 1'b1;
            end
            pbs_pkg::KIND_BYPASS_OPEN:
            begin
                req_mode = pbs_pkg::MODE_BYPASS_OPEN;
                do_visit = 1'b1;
            end
            pbs_pkg::KIND_BYPASS_CLOSE:
            begin
                req_mode = pbs_pkg::MODE_BYPASS_CLOSE;
                do_visit = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        unique case (mode)
            pbs_pkg::MODE_PRIMING:      limit_ms = limits.priming_ms;
            pbs_pkg::MODE_RUNNING:      limit_ms = limits.pump_timeout_ms;
            pbs_pkg::MODE_BLOWOFF:      limit_ms = limits.blowoff_ms;
            pbs_pkg::MODE_BYPASS_OPEN:  limit_ms = limits.bypass_max_ms;
            pbs_pkg::MODE_BYPASS_CLOSE: limit_ms = limits.bypass_close_ms;
            pbs_pkg::MODE_MIX:          limit_ms = limits.pump_timeout_ms;
            default:                    limit_ms = '0;
        endcase
    end

    assign expired = CMP_W'(elapsed_cur) > CMP_W'(limit_ms);

    // A request for a different mode enters it; a request for the current
    // mode only tests that mode's time limit.
    always_comb
    begin
        enter      = 1'b0;
        target     = req_mode;
        en_visit   = en_cmd;
        event_fire = 1'b0;
        if (do_visit)
        begin
            if (req_mode != mode)
            begin
                enter = 1'b1;
            end
            else
            begin
                unique case (mode)
                    pbs_pkg::MODE_PRIMING:
                    begin
                        enter  = expired;
                        target = pbs_pkg::MODE_RUNNING;
                    end
                    pbs_pkg::MODE_RUNNING:
                    begin
                        enter  = expired;
                        target = pbs_pkg::MODE_BLOWOFF;
                        if (expired)
                        begin
                            en_visit   = 1'b0;
                            event_fire = 1'b1;
                        end
                    end
                    pbs_pkg::MODE_BLOWOFF, pbs_pkg::MODE_BYPASS_OPEN:
                    begin
                        enter  = expired;
                        target = pbs_pkg::MODE_BYPASS_CLOSE;
                    end
                    pbs_pkg::MODE_BYPASS_CLOSE:
                    begin
                        enter  = expired;
                        target = en_cmd ? pbs_pkg::MODE_IDLE : pbs_pkg::MODE_DISABLED;
                    end
                    pbs_pkg::MODE_MIX:
                    begin
                        en_visit = 1'b1;
                        enter    = expired;
                        target   = pbs_pkg::MODE_BYPASS_CLOSE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Mode entry sets the drives and restarts the timer.
    always_comb
    begin
        mode_next                = mode;
        elapsed_next             = elapsed_cur;
        flags_next.pump          = flags.pump;
        flags_next.bypass        = flags.bypass;
        flags_next.enabled       = en_visit;
        flags_next.timeout_event = event_fire;
        if (enter)
        begin
            mode_next    = target;
            elapsed_next = '0;
            unique case (target)
                pbs_pkg::MODE_IDLE:
                begin
                    flags_next.pump    = 1'b0;
                    flags_next.bypass  = 1'b0;
                    flags_next.enabled = 1'b1;
                end
                pbs_pkg::MODE_PRIMING:
                begin
                    flags_next.pump   = 1'b1;
                    flags_next.bypass = 1'b1;
                end
                pbs_pkg::MODE_RUNNING:
                begin
                    flags_next.pump    = 1'b1;
                    flags_next.bypass  = 1'b0;
                    flags_next.enabled = 1'b1;
                end
                pbs_pkg::MODE_BLOWOFF, pbs_pkg::MODE_BYPASS_OPEN:
                begin
                    flags_next.pump   = 1'b0;
                    flags_next.bypass = 1'b1;
                end
                pbs_pkg::MODE_BYPASS_CLOSE:
                begin
                    flags_next.pump   = 1'b0;
                    flags_next.bypass = 1'b0;
                end
                pbs_pkg::MODE_MIX:
                begin
                    flags_next.pump    = 1'b1;
                    flags_next.bypass  = 1'b1;
                    flags_next.enabled = 1'b1;
                end
                default:
                begin
                    flags_next.pump    = 1'b0;
                    flags_next.bypass  = 1'b0;
                    flags_next.enabled = 1'b0;
                end
            endcase
        end
    end

endmodule

FILE: hdl/pump_bypass_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pump_bypass_sequencer_unit
// Pump and bypass valve sequencer driven by millisecond ticks and commands.
// ----------------------------------------------------------------------------
// Every input transfer (a tick or a command) yields exactly one result
// transfer carrying the mode, both drives, the enabled flag and the running
// timeout flag. The block takes one item per clock cycle while the result
// register is empty or its result is taken: each item is captured in an input
// register, applied to the sequencer state by one pass of next-state logic
// once the result register is free, and placed in a result register. The
// single state update per cycle sets the rate of one item per cycle. The
// input side keeps taking items while a result waits, as long as the result
// register is freed in the same cycle. Configuration writes take effect at
// the next clock edge.
module pump_bypass_sequencer_unit #(
    parameter int TIMER_BITS = 27
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] reset_enable, [7:1] zero
    input  logic [pbs_pkg::KIND_W-1:0]  s_tuser,   // [3:0] kind
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] mode, [3] pump_on, [4] bypass_on, [5] enabled, [6] timeout_event,
    // [7] zero
    output logic [pbs_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_we,
    input  logic [pbs_pkg::INDEX_W-1:0] cfg_index,
    input  logic [pbs_pkg::CFG_W-1:0]   cfg_wdata
);

    pbs_pkg::pbs_limits_t        limits;

    logic                        in_valid_reg;
    logic [pbs_pkg::KIND_W-1:0]  in_kind_reg;
    logic                        in_reset_enable_reg;

    logic [pbs_pkg::MODE_W-1:0]  mode_reg;
    logic [pbs_pkg::MODE_W-1:0]  mode_next;
    logic [TIMER_BITS-1:0]       elapsed_reg;
    logic [TIMER_BITS-1:0]       elapsed_next;
    pbs_pkg::pbs_flags_t         flags_reg;
    pbs_pkg::pbs_flags_t         flags_next;

    logic                        out_valid_reg;
    logic [pbs_pkg::OUT_W-1:0]   out_data_reg;

    logic                        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .limits    (limits)
    );

    pbs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .kind         (in_kind_reg),
        .reset_enable (in_reset_enable_reg),
        .limits       (limits),
        .mode         (mode_reg),
        .elapsed      (elapsed_reg),
        .flags        (flags_reg),
        .mode_next    (mode_next),
        .elapsed_next (elapsed_next),
        .flags_next   (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg         <= s_tuser;
            in_reset_enable_reg <= s_tdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg                <= pbs_pkg::ENABLE_AT_RESET ? pbs_pkg::MODE_IDLE
                                                                : pbs_pkg::MODE_DISABLED;
            elapsed_reg             <= '0;
            flags_reg.pump          <= 1'b0;
            flags_reg.bypass        <= 1'b0;
            flags_reg.enabled       <= pbs_pkg::ENABLE_AT_RESET;
            flags_reg.timeout_event <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg    <= mode_next;
                elapsed_reg <= elapsed_next;
                flags_reg   <= flags_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {1'b0, flags_next.timeout_event, flags_next.enabled,
                             flags_next.bypass, flags_next.pump, mode_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hdl/pbs_checker.sv
// ----------------------------------------------------------------------------
// pbs_checker
// Port-level checks of the pump and bypass sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pbs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [pbs_pkg::OUT_W-1:0] m_tdata
);

    logic [pbs_pkg::MODE_W-1:0] res_mode;
    logic                       res_pump;
    logic                       res_enabled;
    logic                       res_event;

    assign res_mode    = m_tdata[2:0];
    assign res_pump    = m_tdata[3];
    assign res_enabled = m_tdata[5];
    assign res_event   = m_tdata[6];

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The pump only runs while priming, running or mixing.
    a_pump_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_pump |-> (res_mode == pbs_pkg::MODE_PRIMING ||
                                  res_mode == pbs_pkg::MODE_RUNNING ||
                                  res_mode == pbs_pkg::MODE_MIX))
        else $error("pump on in a mode without pump");

    // A running timeout always lands in blow-off with the enable dropped.
    a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_event |-> res_mode == pbs_pkg::MODE_BLOWOFF && !res_enabled)
        else $error("timeout reported outside blow-off");

    // Disabled means both drives off and the enable cleared.
    a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res_mode == pbs_pkg::MODE_DISABLED |-> m_tdata[5:3] == 3'b000)
        else $error("disabled mode with a drive or enable set");

endmodule

bind pump_bypass_sequencer_unit pbs_checker u_pbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
